>>> sv/dsvw_pkg.sv
// Shared types, constants and small lookup functions for the date text checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package dsvw_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [15:0] ACCUM_MAX = 16'hFFFF;
  localparam logic [15:0] YEAR_MAX  = 16'd9999;
  localparam logic [15:0] MONTH_MAX = 16'd12;
  localparam logic [15:0] DAY_MAX   = 16'd31;

  // floor(x * 2^19 / 100) rounded up; exact for x below 10000
  localparam logic [12:0] RECIP_100 = 13'd5243;
  // floor(x * 2^18 / 7) rounded up; exact for x below about 40000
  localparam logic [15:0] RECIP_7   = 16'd37450;

  typedef enum logic [1:0] {
    FLD_DAY   = 2'd0,
    FLD_MONTH = 2'd1,
    FLD_YEAR  = 2'd2
  } field_t;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_NUM  = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  // one parsed string, handed from the scanner to the checker
  typedef struct packed {
    logic        pre_ok;
    logic [15:0] day;
    logic [15:0] month;
    logic [15:0] year;
  } rec_t;

  // (3 * (mm + 1)) / 5 for the shifted month 3..14
  function automatic logic [3:0] month_term(input logic [3:0] mm);
    logic [3:0] t;
    unique case (mm)
      4'd3:    t = 4'd2;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd3;
      4'd6:    t = 4'd4;
      4'd7:    t = 4'd4;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      4'd10:   t = 4'd6;
      4'd11:   t = 4'd7;
      4'd12:   t = 4'd7;
      4'd13:   t = 4'd8;
      4'd14:   t = 4'd9;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd2:                         n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/dsvw_if.sv
// Handshake interfaces for the character stream and the result stream.
// Depends on nothing; used by the top level and its drivers.
`default_nettype none

interface dsvw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dsvw_result_if;
  logic        valid;
  logic        ready;
  logic        date_ok;
  logic [4:0]  day_value;
  logic [3:0]  month_value;
  logic [13:0] year_value;
  logic [2:0]  weekday;

  modport source (output valid, output date_ok, output day_value, output month_value,
                  output year_value, output weekday, input ready);
  modport sink   (input valid, input date_ok, input day_value, input month_value,
                  input year_value, input weekday, output ready);
endinterface

`default_nettype wire

>>> sv/dsvw_scan.sv
// Front end: scans one character per cycle while the queue has room into the
// three field accumulators, queuing a record on the terminator. Uses dsvw_pkg.
`default_nettype none

module dsvw_scan
  import dsvw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  output logic            push_valid,
  input  wire logic       push_ready,
  output rec_t            push_rec
);

  field_t      field_number, field_number_next;
  phase_t      scan_phase, scan_phase_next;
  logic        minus_seen, minus_seen_next;
  logic [15:0] day_accum, day_accum_next;
  logic [15:0] month_accum, month_accum_next;
  logic [15:0] year_accum, year_accum_next;
  logic [2:0]  sign_flags, sign_flags_next;

  logic        take;
  logic        is_term, is_dot, is_blank, is_sign, is_digit;
  logic [15:0] acc_cur, acc_new;
  logic [19:0] acc_mul;
  logic        year_neg;

  assign in_ready = push_ready;
  assign take     = in_valid && push_ready;

  assign is_term  = (char_code == CHAR_NUL);
  assign is_dot   = (char_code == CHAR_DOT) && (field_number != FLD_YEAR);
  assign is_blank = (char_code == CHAR_SPACE) ||
                    ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
  assign is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

  always_comb begin
    unique case (field_number)
      FLD_DAY:   acc_cur = day_accum;
      FLD_MONTH: acc_cur = month_accum;
      default:   acc_cur = year_accum;
    endcase
  end

  // acc * 10 + digit, saturating
  assign acc_mul = {acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0} +
                   {12'd0, char_code - CHAR_ZERO};
  assign acc_new = (acc_mul > {4'd0, ACCUM_MAX}) ? ACCUM_MAX : acc_mul[15:0];

  assign year_neg   = sign_flags[2] || ((field_number == FLD_YEAR) && minus_seen);
  assign push_valid = in_valid && is_term;

  always_comb begin
    push_rec.pre_ok = (field_number == FLD_YEAR) && !sign_flags[0] && !sign_flags[1] &&
                      !(year_neg && (year_accum != 16'd0));
    push_rec.day    = day_accum;
    push_rec.month  = month_accum;
    push_rec.year   = year_accum;
  end

  always_comb begin
    field_number_next = field_number;
    scan_phase_next   = scan_phase;
    minus_seen_next   = minus_seen;
    day_accum_next    = day_accum;
    month_accum_next  = month_accum;
    year_accum_next   = year_accum;
    sign_flags_next   = sign_flags;
    if (take) begin
      priority if (is_term) begin
        field_number_next = FLD_DAY;
        scan_phase_next   = PH_SKIP;
        minus_seen_next   = 1'b0;
        day_accum_next    = '0;
        month_accum_next  = '0;
        year_accum_next   = '0;
        sign_flags_next   = '0;
      end else if (is_dot) begin
        if (field_number == FLD_DAY) begin
          sign_flags_next[0] = sign_flags[0] | minus_seen;
          field_number_next  = FLD_MONTH;
        end else begin
          sign_flags_next[1] = sign_flags[1] | minus_seen;
          field_number_next  = FLD_YEAR;
        end
        scan_phase_next = PH_SKIP;
        minus_seen_next = 1'b0;
      end else if ((scan_phase == PH_SKIP) && is_blank) begin
        scan_phase_next = PH_SKIP;
      end else if ((scan_phase == PH_SKIP) && is_sign) begin
        minus_seen_next = (char_code == CHAR_MINUS);
        scan_phase_next = PH_NUM;
      end else if (scan_phase != PH_STOP) begin
        if (is_digit) begin
          scan_phase_next = PH_NUM;
          unique case (field_number)
            FLD_DAY:   day_accum_next   = acc_new;
            FLD_MONTH: month_accum_next = acc_new;
            default:   year_accum_next  = acc_new;
          endcase
        end else begin
          scan_phase_next = PH_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number <= FLD_DAY;
      scan_phase   <= PH_SKIP;
      minus_seen   <= 1'b0;
      day_accum    <= '0;
      month_accum  <= '0;
      year_accum   <= '0;
      sign_flags   <= '0;
    end else begin
      field_number <= field_number_next;
      scan_phase   <= scan_phase_next;
      minus_seen   <= minus_seen_next;
      day_accum    <= day_accum_next;
      month_accum  <= month_accum_next;
      year_accum   <= year_accum_next;
      sign_flags   <= sign_flags_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/dsvw_queue.sv
// Short record queue between scanner and checker, so each side stalls on its own.
// Uses rec_t from dsvw_pkg. DEPTH must be 2 or more.
`default_nettype none

module dsvw_queue
  import dsvw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  rec_t      push_rec,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output rec_t      pop_rec
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  rec_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_rec    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/dsvw_check.sv
// Back end: three-stage pipeline that range-checks a record, applies the leap
// year rule and works out the weekday. Uses dsvw_pkg.
`default_nettype none

module dsvw_check
  import dsvw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  rec_t        pop_rec,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic        date_ok,
  output logic [4:0]  day_value,
  output logic [3:0]  month_value,
  output logic [13:0] year_value,
  output logic [2:0]  weekday
);

  logic        adv;
  logic        v1, v2;

  // stage 1
  logic        ok1, borrow1, neg1;
  logic [4:0]  d1;
  logic [3:0]  m1;
  logic [13:0] y1, yy1;
  logic [6:0]  qy1, qyy1;
  logic [13:0] y_tr, yy_c;
  logic        borrow_c;
  logic [26:0] prod_y, prod_yy;

  // stage 2
  logic        ok2;
  logic [4:0]  d2;
  logic [3:0]  m2;
  logic [13:0] y2;
  logic [15:0] h2;
  logic [13:0] q7_2;
  logic [3:0]  mm_c;
  logic [13:0] rem100;
  logic        leap_c;
  logic [15:0] h_c;
  logic [31:0] prod_h;

  logic [15:0] r_c;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  assign y_tr     = pop_rec.year[13:0];
  assign borrow_c = (pop_rec.month[3:0] < 4'd3);
  assign yy_c     = (borrow_c && (y_tr != '0)) ? y_tr - 1'b1 : y_tr;
  assign prod_y   = {13'd0, y_tr} * {14'd0, RECIP_100};
  assign prod_yy  = {13'd0, yy_c} * {14'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1 <= pop_rec.pre_ok && (pop_rec.day != '0) && (pop_rec.day <= DAY_MAX) &&
             (pop_rec.month != '0) && (pop_rec.month <= MONTH_MAX) &&
             (pop_rec.year <= YEAR_MAX);
      d1      <= pop_rec.day[4:0];
      m1      <= pop_rec.month[3:0];
      y1      <= y_tr;
      yy1     <= yy_c;
      borrow1 <= borrow_c;
      // year zero in January or February stands for year minus one
      neg1    <= borrow_c && (y_tr == '0);
      qy1     <= prod_y[25:19];
      qyy1    <= prod_yy[25:19];
    end
  end

  assign rem100 = y1 - 14'(qy1) * 14'd100;
  assign leap_c = ((y1[1:0] == 2'b00) && (rem100 != '0)) ||
                  ((rem100 == '0) && (qy1[1:0] == 2'b00));
  assign mm_c   = borrow1 ? m1 + 4'd12 : m1;
  assign h_c    = 16'(d1) + {11'd0, mm_c, 1'b0} + 16'(month_term(mm_c)) + 16'(yy1) -
                  16'(neg1) + 16'(yy1[13:2]) - 16'(qyy1) + 16'(qyy1[6:2]);
  assign prod_h = h_c * RECIP_7;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok2  <= ok1 && (d1 <= month_len(m1, leap_c));
      d2   <= d1;
      m2   <= m1;
      y2   <= y1;
      h2   <= h_c;
      q7_2 <= prod_h[31:18];
    end
  end

  assign r_c = h2 - 16'(q7_2) * 16'd7;

  always_ff @(posedge clk) begin
    if (adv) begin
      date_ok     <= ok2;
      day_value   <= ok2 ? d2 : '0;
      month_value <= ok2 ? m2 : '0;
      year_value  <= ok2 ? y2 : '0;
      weekday     <= ok2 ? r_c[2:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

`default_nettype wire

>>> sv/date_string_validate_weekday.sv
// Date text checker: one character per cycle in, one result per terminator out.
// The record lands in the queue on the terminator's accepting edge and then
// passes the three check stages before the result is valid.
// Throughput: one character every cycle; the check pipeline and the queue take a
// record per cycle, so input stalls only when the result side holds back.
// Reset (rst, synchronous) clears the scanner state, queue pointers and stage valids.
`default_nettype none

module date_string_validate_weekday
  import dsvw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  dsvw_char_if.sink     text,
  dsvw_result_if.source result
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  rec_t push_rec, pop_rec;

  dsvw_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (text.valid),
    .in_ready   (text.ready),
    .char_code  (text.char_code),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  dsvw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  dsvw_check u_check (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_rec     (pop_rec),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .date_ok     (result.date_ok),
    .day_value   (result.day_value),
    .month_value (result.month_value),
    .year_value  (result.year_value),
    .weekday     (result.weekday)
  );

endmodule

`default_nettype wire
